// ===== src/lru_index_linked_list_top_defines.svh =====
// Assertion macros shared by the LRU list RTL.
`ifndef LRU_INDEX_LINKED_LIST_TOP_DEFINES_SVH
`define LRU_INDEX_LINKED_LIST_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, checked out of reset.
`define LRU_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: lbl");

// Next-cycle implication, checked out of reset.
`define LRU_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: lbl");

`else

`define LRU_ASSERT_IMP(lbl, ante, cons)
`define LRU_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

// ===== src/lru_ll_pkg.sv =====
// Types, codes and microcode table of the LRU linked list sequencer.
`timescale 1ns / 1ps

package lru_ll_pkg;

  // Field widths
  localparam int EW          = 10;
  localparam int MODE_W      = 3;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 24;
  localparam int POOL_MAX    = 1 << EW;
  localparam int ENTRIES_DEF = 1024;

  // Request codes
  localparam logic [MODE_W-1:0] MODE_ADD_HEAD  = 3'd0;
  localparam logic [MODE_W-1:0] MODE_ADD_TAIL  = 3'd1;
  localparam logic [MODE_W-1:0] MODE_MOVE_HEAD = 3'd2;
  localparam logic [MODE_W-1:0] MODE_MOVE_TAIL = 3'd3;
  localparam logic [MODE_W-1:0] MODE_REMOVE    = 3'd4;
  localparam logic [MODE_W-1:0] MODE_QUERY     = 3'd5;

  // Microprogram steps
  typedef enum logic [3:0] {
    UPC_IDLE,
    UPC_DECIDE,
    UPC_U1,
    UPC_U2,
    UPC_LH1,
    UPC_LH2,
    UPC_LT1,
    UPC_LT2,
    UPC_EMIT
  } upc_t;

  // Operand sources for link addresses and link data
  localparam int SRC_N = 6;
  typedef enum logic [2:0] {
    SRC_E,       // named entry
    SRC_P,       // its prev link as read
    SRC_Q,       // its next link as read
    SRC_NEWEST,  // root next link, current
    SRC_OLDEST,  // root prev link, current
    SRC_ROOT     // the root sentinel
  } src_t;

  // Jump conditions
  typedef enum logic [2:0] {
    JC_JUMP,      // always go to target
    JC_WAIT,      // go to target once an item is accepted
    JC_DISPATCH,  // guard and mode pick the first step
    JC_UNLINKED,  // mode picks the step after unlinking
    JC_EMIT       // go to target once the result register is free
  } jc_t;

  // One control word
  typedef struct packed {
    logic p_we;
    src_t p_addr;
    src_t p_data;
    logic n_we;
    src_t n_addr;
    src_t n_data;
    jc_t  jc;
    upc_t target;
  } ucode_t;

  localparam ucode_t UC_NOP = '{
    p_we: 1'b0, p_addr: SRC_E, p_data: SRC_E,
    n_we: 1'b0, n_addr: SRC_E, n_data: SRC_E,
    jc: JC_JUMP, target: UPC_IDLE
  };

  // Control store
  function automatic ucode_t ucode(upc_t step);
    ucode_t w;
    w = UC_NOP;
    case (step)
      UPC_IDLE: begin
        w.jc     = JC_WAIT;
        w.target = UPC_DECIDE;
      end
      UPC_DECIDE: begin
        w.jc = JC_DISPATCH;
      end
      // unlink: prev[q] = p, next[p] = q
      UPC_U1: begin
        w.p_we = 1'b1; w.p_addr = SRC_Q; w.p_data = SRC_P;
        w.n_we = 1'b1; w.n_addr = SRC_P; w.n_data = SRC_Q;
        w.target = UPC_U2;
      end
      // unlink: entry points to itself
      UPC_U2: begin
        w.p_we = 1'b1; w.p_addr = SRC_E; w.p_data = SRC_E;
        w.n_we = 1'b1; w.n_addr = SRC_E; w.n_data = SRC_E;
        w.jc   = JC_UNLINKED;
      end
      // link at head: between root and the newest entry
      UPC_LH1: begin
        w.p_we = 1'b1; w.p_addr = SRC_NEWEST; w.p_data = SRC_E;
        w.n_we = 1'b1; w.n_addr = SRC_E;      w.n_data = SRC_NEWEST;
        w.target = UPC_LH2;
      end
      UPC_LH2: begin
        w.p_we = 1'b1; w.p_addr = SRC_E;    w.p_data = SRC_ROOT;
        w.n_we = 1'b1; w.n_addr = SRC_ROOT; w.n_data = SRC_E;
        w.target = UPC_EMIT;
      end
      // link at tail: between the oldest entry and root
      UPC_LT1: begin
        w.p_we = 1'b1; w.p_addr = SRC_E;      w.p_data = SRC_OLDEST;
        w.n_we = 1'b1; w.n_addr = SRC_OLDEST; w.n_data = SRC_E;
        w.target = UPC_LT2;
      end
      UPC_LT2: begin
        w.p_we = 1'b1; w.p_addr = SRC_ROOT; w.p_data = SRC_E;
        w.n_we = 1'b1; w.n_addr = SRC_E;    w.n_data = SRC_ROOT;
        w.target = UPC_EMIT;
      end
      UPC_EMIT: begin
        w.jc     = JC_EMIT;
        w.target = UPC_IDLE;
      end
      default: w = UC_NOP;
    endcase
    return w;
  endfunction

  // First step of an applied request
  function automatic upc_t start_step(logic [MODE_W-1:0] mode);
    upc_t s;
    case (mode) inside
      MODE_ADD_HEAD:                             s = UPC_LH1;
      MODE_ADD_TAIL:                             s = UPC_LT1;
      MODE_MOVE_HEAD, MODE_MOVE_TAIL, MODE_REMOVE: s = UPC_U1;
      default:                                   s = UPC_EMIT;
    endcase
    return s;
  endfunction

  // Step after the entry has been unlinked
  function automatic upc_t after_unlink(logic [MODE_W-1:0] mode);
    upc_t s;
    case (mode)
      MODE_MOVE_HEAD: s = UPC_LH1;
      MODE_MOVE_TAIL: s = UPC_LT1;
      default:        s = UPC_EMIT;
    endcase
    return s;
  endfunction

endpackage

// ===== src/lru_index_linked_list_top.sv =====
// LRU order kept as a circular doubly linked list, run by a microcoded sequencer.
`timescale 1ns / 1ps

// Keeps an LRU order over a pool of ENTRIES entries (at most 1024 are addressable)
// in two link tables, one memory each, with entry 0 as the root sentinel whose links
// are held in registers. One item is worked at a time. Each link table takes one
// write per cycle, so a request costs one microcode step per pair of link writes:
// after acceptance it passes DECIDE, U1 and U2 for a remove, LH1 and LH2 or LT1 and
// LT2 for an add, both pairs for a move, none for a query or a rejection, then EMIT,
// which waits for a free result register; the next item is accepted back in IDLE,
// and the result register lets it in while a result waits. After reset a clearing
// pass over min(ENTRIES, 1024) entries (1024 by default) makes every entry point to
// itself; no item is accepted before it ends. in_tdata carries mode and entry;
// out_tdata carries applied, list_empty, newest_entry, oldest_entry, entry_linked.

`include "lru_index_linked_list_top_defines.svh"

module lru_index_linked_list_top #(
  parameter int ENTRIES = lru_ll_pkg::ENTRIES_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // in_tdata: mode[2:0], entry[12:3], zero[15:13]
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [lru_ll_pkg::IN_TDATA_W-1:0]  in_tdata,
  // out_tdata: applied[0], list_empty[1], newest_entry[11:2],
  //            oldest_entry[21:12], entry_linked[22], zero[23]
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [lru_ll_pkg::OUT_TDATA_W-1:0] out_tdata
);

  import lru_ll_pkg::*;

  localparam int DEPTH = (ENTRIES < POOL_MAX) ? ENTRIES : POOL_MAX;
  localparam int AW    = $clog2(DEPTH);

  // Link tables
  logic [AW-1:0] prev_mem [DEPTH];
  logic [AW-1:0] next_mem [DEPTH];
  logic [AW-1:0] prev_rd_r;
  logic [AW-1:0] next_rd_r;

  // Root links
  logic [AW-1:0] root_next_r;
  logic [AW-1:0] root_prev_r;

  // Clearing pass
  logic          clearing_r;
  logic [AW-1:0] clr_r;

  // Sequencer
  upc_t   upc_r;
  upc_t   upc_nxt;
  ucode_t uc;

  // Request registers
  logic [MODE_W-1:0] mode_r;
  logic [EW-1:0]     ent_r;
  logic              valid_r;
  logic              applied_r;
  logic [AW-1:0]     ent_next_r;

  // Result register
  logic                   out_tvalid_r;
  logic [OUT_TDATA_W-1:0] out_tdata_r;

  logic              in_fire;
  logic [MODE_W-1:0] in_mode;
  logic [EW-1:0]     in_entry;
  logic              in_valid;
  logic              slot_free;
  logic [AW-1:0]     ent_addr;
  logic              guard;
  logic              detached;
  logic              attached;
  logic              entry_linked;

  logic [AW-1:0] src_val [SRC_N];
  logic          prev_we;
  logic [AW-1:0] prev_wa;
  logic [AW-1:0] prev_wd;
  logic          next_we;
  logic [AW-1:0] next_wa;
  logic [AW-1:0] next_wd;

  // Input unpacking
  assign in_mode  = in_tdata[MODE_W-1:0];
  assign in_entry = in_tdata[MODE_W+EW-1:MODE_W];
  assign in_valid = (ENTRIES >= POOL_MAX) || (in_entry < EW'(ENTRIES));

  assign in_tready = !clearing_r && (upc_r == UPC_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign slot_free = !out_tvalid_r || out_tready;
  assign ent_addr  = ent_r[AW-1:0];

  // Control word of the current step
  always_comb begin
    uc = ucode(upc_r);
  end

  // Guard conditions, evaluated on the links read for the entry
  always_comb begin
    detached = (prev_rd_r == ent_addr) && (next_rd_r == ent_addr);
    attached = (prev_rd_r != ent_addr) && (next_rd_r != ent_addr);
    case (mode_r) inside
      MODE_ADD_HEAD, MODE_ADD_TAIL: guard = detached;
      MODE_MOVE_HEAD:
        guard = attached && (prev_rd_r != '0) && (next_rd_r != prev_rd_r);
      MODE_MOVE_TAIL:
        guard = attached && (next_rd_r != '0) && (next_rd_r != prev_rd_r);
      MODE_REMOVE:                  guard = attached;
      default:                      guard = 1'b0;
    endcase
    guard = guard && valid_r && (ent_r != '0);
  end

  // Next step
  always_comb begin
    case (uc.jc)
      JC_WAIT:     upc_nxt = in_fire ? uc.target : upc_r;
      JC_DISPATCH: upc_nxt = guard ? start_step(mode_r) : UPC_EMIT;
      JC_UNLINKED: upc_nxt = after_unlink(mode_r);
      JC_EMIT:     upc_nxt = slot_free ? uc.target : upc_r;
      default:     upc_nxt = uc.target;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r <= UPC_IDLE;
    end else begin
      upc_r <= upc_nxt;
    end
  end

  // Operand sources
  always_comb begin
    src_val[SRC_E]      = ent_addr;
    src_val[SRC_P]      = prev_rd_r;
    src_val[SRC_Q]      = next_rd_r;
    src_val[SRC_NEWEST] = root_next_r;
    src_val[SRC_OLDEST] = root_prev_r;
    src_val[SRC_ROOT]   = '0;
  end

  // Write ports: clearing pass or the step's link writes
  always_comb begin
    prev_we = clearing_r || uc.p_we;
    prev_wa = clearing_r ? clr_r : src_val[uc.p_addr];
    prev_wd = clearing_r ? clr_r : src_val[uc.p_data];
    next_we = clearing_r || uc.n_we;
    next_wa = clearing_r ? clr_r : src_val[uc.n_addr];
    next_wd = clearing_r ? clr_r : src_val[uc.n_data];
  end

  // Link tables: one write and one registered read each
  always_ff @(posedge clk) begin
    if (prev_we) begin
      prev_mem[prev_wa] <= prev_wd;
    end
    if (in_fire) begin
      prev_rd_r <= prev_mem[in_entry[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (next_we) begin
      next_mem[next_wa] <= next_wd;
    end
    if (in_fire) begin
      next_rd_r <= next_mem[in_entry[AW-1:0]];
    end
  end

  // Root links live in registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      root_prev_r <= '0;
      root_next_r <= '0;
    end else begin
      if (prev_we && (prev_wa == '0)) begin
        root_prev_r <= prev_wd;
      end
      if (next_we && (next_wa == '0)) begin
        root_next_r <= next_wd;
      end
    end
  end

  // Clearing pass after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_r      <= '0;
    end else if (clearing_r) begin
      clr_r <= clr_r + AW'(1);
      if (clr_r == AW'(DEPTH - 1)) begin
        clearing_r <= 1'b0;
      end
    end
  end

  // Request capture, guard result and the entry's own next link
  always_ff @(posedge clk) begin
    if (in_fire) begin
      mode_r  <= in_mode;
      ent_r   <= in_entry;
      valid_r <= in_valid;
    end
    if (upc_r == UPC_DECIDE) begin
      applied_r  <= guard;
      ent_next_r <= next_rd_r;
    end else if (uc.n_we && (next_wa == ent_addr)) begin
      ent_next_r <= next_wd;
    end
  end

  assign entry_linked = valid_r &&
                        ((ent_r == '0) ? (root_next_r != '0) : (ent_next_r != ent_addr));

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if ((upc_r == UPC_EMIT) && slot_free) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((upc_r == UPC_EMIT) && slot_free) begin
      out_tdata_r <= {1'b0, entry_linked, EW'(root_prev_r), EW'(root_next_r),
                      (root_next_r == '0), applied_r};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  // Checks
  `LRU_ASSERT_IMP(a_one_item, (upc_r != UPC_IDLE), !in_tready)
  `LRU_ASSERT_NXT(a_accept_decides, in_fire, (upc_r == UPC_DECIDE))
  `LRU_ASSERT_IMP(a_root_links_agree, upc_r == UPC_IDLE, (root_next_r == '0) == (root_prev_r == '0))
  `LRU_ASSERT_NXT(a_emit_loads, ((upc_r == UPC_EMIT) && slot_free), out_tvalid)

endmodule

// ===== verif/tb_lru_index_linked_list_top.sv =====
// Self-checking testbench for the LRU linked list: directed table, then random traffic.
`timescale 1ns / 1ps

module tb_lru_index_linked_list_top;
  import lru_ll_pkg::*;

  // Modes with no operation behind them
  localparam logic [MODE_W-1:0] MODE_UNUSED_6 = 3'd6;
  localparam logic [MODE_W-1:0] MODE_UNUSED_7 = 3'd7;
  localparam logic [EW-1:0]     ROOT          = '0;
  localparam logic [EW-1:0]     TOP_ENTRY     = '1;
  localparam int                RANDOM_ITEMS  = 2000;
  localparam int                PHASES        = 4;
  localparam int                WATCHDOG_MAX  = 20000;
  localparam int                DRAIN_CYCLES  = 20;

  // One result, unpacked
  typedef struct packed {
    logic          applied;
    logic          list_empty;
    logic [EW-1:0] newest_entry;
    logic [EW-1:0] oldest_entry;
    logic          entry_linked;
  } lru_result_t;

  // Directed stimulus row; checked against the typed result when known is set
  typedef struct {
    logic [MODE_W-1:0] mode;
    logic [EW-1:0]     ent;
    bit                known;
    lru_result_t       result;
  } req_row_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;

  // Shadow copy of the link tables
  logic [EW-1:0] prev_tbl [POOL_MAX];
  logic [EW-1:0] next_tbl [POOL_MAX];

  lru_result_t pending_results [$];
  req_row_t    req_rows [$];
  int          err_cnt = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          quiet_cycles = 0;

  lru_index_linked_list_top u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Insert n between p and q, same write order as the head link update
  function automatic void link_in(logic [EW-1:0] n, logic [EW-1:0] p, logic [EW-1:0] q);
    prev_tbl[q] = n;
    next_tbl[n] = q;
    prev_tbl[n] = p;
    next_tbl[p] = n;
  endfunction

  function automatic void unlink(logic [EW-1:0] n);
    logic [EW-1:0] p;
    logic [EW-1:0] q;
    p = prev_tbl[n];
    q = next_tbl[n];
    prev_tbl[q] = p;
    next_tbl[p] = q;
    prev_tbl[n] = n;
    next_tbl[n] = n;
  endfunction

  // Apply one request to the shadow tables and return its result
  function automatic lru_result_t apply_request(logic [MODE_W-1:0] mode, logic [EW-1:0] ent);
    lru_result_t r;
    logic [EW-1:0] p;
    logic [EW-1:0] q;
    logic          detached;
    logic          attached;
    r = '0;
    if (ent != ROOT) begin
      p = prev_tbl[ent];
      q = next_tbl[ent];
      detached = (p == ent) && (q == ent);
      attached = (p != ent) && (q != ent);
      case (mode)
        MODE_ADD_HEAD: begin
          if (detached) begin
            link_in(ent, ROOT, next_tbl[ROOT]);
            r.applied = 1'b1;
          end
        end
        MODE_ADD_TAIL: begin
          if (detached) begin
            link_in(ent, prev_tbl[ROOT], ROOT);
            r.applied = 1'b1;
          end
        end
        MODE_MOVE_HEAD: begin
          if (attached && p != ROOT && q != p) begin
            unlink(ent);
            link_in(ent, ROOT, next_tbl[ROOT]);
            r.applied = 1'b1;
          end
        end
        MODE_MOVE_TAIL: begin
          if (attached && q != ROOT && q != p) begin
            unlink(ent);
            link_in(ent, prev_tbl[ROOT], ROOT);
            r.applied = 1'b1;
          end
        end
        MODE_REMOVE: begin
          if (attached) begin
            unlink(ent);
            r.applied = 1'b1;
          end
        end
        default: ;
      endcase
    end
    r.list_empty   = (next_tbl[ROOT] == ROOT);
    r.newest_entry = next_tbl[ROOT];
    r.oldest_entry = prev_tbl[ROOT];
    r.entry_linked = (next_tbl[ent] != ent);
    return r;
  endfunction

  // Present one item, wait for acceptance, then queue its expected result
  task automatic send_item(input req_row_t row);
    lru_result_t predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {{(IN_TDATA_W-EW-MODE_W){1'b0}}, row.ent, row.mode};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predicted = apply_request(row.mode, row.ent);
    pending_results.push_back(row.known ? row.result : predicted);
  endtask

  // Random request, mostly on a small working set so the list fills and churns
  function automatic req_row_t random_request(int working_set);
    req_row_t row;
    int       pick;
    pick = $urandom_range(99);
    if (pick < 25)      row.mode = $urandom_range(1) ? MODE_ADD_TAIL : MODE_ADD_HEAD;
    else if (pick < 55) row.mode = $urandom_range(1) ? MODE_MOVE_TAIL : MODE_MOVE_HEAD;
    else if (pick < 75) row.mode = MODE_REMOVE;
    else if (pick < 90) row.mode = MODE_QUERY;
    else                row.mode = $urandom_range(1) ? MODE_UNUSED_7 : MODE_UNUSED_6;
    pick = $urandom_range(99);
    if (pick < 80)      row.ent = EW'($urandom_range(working_set, 1));
    else if (pick < 92) row.ent = EW'($urandom_range(POOL_MAX - 1));
    else                row.ent = $urandom_range(1) ? TOP_ENTRY : ROOT;
    row.known  = 1'b0;
    row.result = '0;
    return row;
  endfunction

  // Result side: random stall and in-order compare
  always @(posedge clk) begin
    lru_result_t got;
    lru_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.applied      = out_tdata[0];
      got.list_empty   = out_tdata[1];
      got.newest_entry = out_tdata[11:2];
      got.oldest_entry = out_tdata[21:12];
      got.entry_linked = out_tdata[22];
      if (pending_results.size() == 0) begin
        $error("unexpected result item: %h", out_tdata);
        err_cnt++;
      end else begin
        want = pending_results.pop_front();
        if (got.applied !== want.applied) begin
          $error("applied: expected %0d, got %0d", want.applied, got.applied);
          err_cnt++;
        end
        if (got.list_empty !== want.list_empty) begin
          $error("list_empty: expected %0d, got %0d", want.list_empty, got.list_empty);
          err_cnt++;
        end
        if (got.newest_entry !== want.newest_entry) begin
          $error("newest_entry: expected %0d, got %0d", want.newest_entry, got.newest_entry);
          err_cnt++;
        end
        if (got.oldest_entry !== want.oldest_entry) begin
          $error("oldest_entry: expected %0d, got %0d", want.oldest_entry, got.oldest_entry);
          err_cnt++;
        end
        if (got.entry_linked !== want.entry_linked) begin
          $error("entry_linked: expected %0d, got %0d", want.entry_linked, got.entry_linked);
          err_cnt++;
        end
      end
    end
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Watchdog: cycles with no item moving on either side; covers the clearing pass
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_MAX) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int working_set;
    for (int i = 0; i < POOL_MAX; i++) begin
      prev_tbl[i] = EW'(i);
      next_tbl[i] = EW'(i);
    end

    // Directed table: empty list, root, rejections, extremes, every mode
    req_rows.push_back('{MODE_QUERY,     10'd5,     1'b1, '{1'b0, 1'b1, 10'd0,    10'd0, 1'b0}});
    req_rows.push_back('{MODE_QUERY,     ROOT,      1'b1, '{1'b0, 1'b1, 10'd0,    10'd0, 1'b0}});
    req_rows.push_back('{MODE_REMOVE,    10'd7,     1'b1, '{1'b0, 1'b1, 10'd0,    10'd0, 1'b0}});
    req_rows.push_back('{MODE_MOVE_HEAD, 10'd7,     1'b1, '{1'b0, 1'b1, 10'd0,    10'd0, 1'b0}});
    req_rows.push_back('{MODE_ADD_HEAD,  ROOT,      1'b1, '{1'b0, 1'b1, 10'd0,    10'd0, 1'b0}});
    req_rows.push_back('{MODE_ADD_HEAD,  TOP_ENTRY, 1'b1, '{1'b1, 1'b0, 10'd1023, 10'd1023, 1'b1}});
    req_rows.push_back('{MODE_ADD_TAIL,  10'd1,     1'b1, '{1'b1, 1'b0, 10'd1023, 10'd1, 1'b1}});
    req_rows.push_back('{MODE_ADD_HEAD,  TOP_ENTRY, 1'b1, '{1'b0, 1'b0, 10'd1023, 10'd1, 1'b1}});
    // already newest / already oldest
    req_rows.push_back('{MODE_MOVE_HEAD, TOP_ENTRY, 1'b1, '{1'b0, 1'b0, 10'd1023, 10'd1, 1'b1}});
    req_rows.push_back('{MODE_MOVE_TAIL, 10'd1,     1'b1, '{1'b0, 1'b0, 10'd1023, 10'd1, 1'b1}});
    // root named on a non-empty list reports linked
    req_rows.push_back('{MODE_QUERY,     ROOT,      1'b1, '{1'b0, 1'b0, 10'd1023, 10'd1, 1'b1}});
    req_rows.push_back('{MODE_ADD_HEAD,  10'd682,   1'b0, '{default: '0}});
    req_rows.push_back('{MODE_ADD_TAIL,  10'd341,   1'b0, '{default: '0}});
    req_rows.push_back('{MODE_MOVE_HEAD, 10'd1,     1'b0, '{default: '0}});
    req_rows.push_back('{MODE_MOVE_TAIL, TOP_ENTRY, 1'b0, '{default: '0}});
    req_rows.push_back('{MODE_UNUSED_6,  10'd682,   1'b0, '{default: '0}});
    req_rows.push_back('{MODE_UNUSED_7,  10'd341,   1'b0, '{default: '0}});
    req_rows.push_back('{MODE_REMOVE,    10'd682,   1'b0, '{default: '0}});
    req_rows.push_back('{MODE_MOVE_HEAD, 10'd341,   1'b0, '{default: '0}});
    req_rows.push_back('{MODE_REMOVE,    10'd1,     1'b0, '{default: '0}});
    req_rows.push_back('{MODE_REMOVE,    TOP_ENTRY, 1'b0, '{default: '0}});
    req_rows.push_back('{MODE_REMOVE,    10'd341,   1'b0, '{default: '0}});
    // single-entry list: both links point at the root, moves rejected
    req_rows.push_back('{MODE_ADD_TAIL,  10'd2,     1'b0, '{default: '0}});
    req_rows.push_back('{MODE_MOVE_HEAD, 10'd2,     1'b0, '{default: '0}});
    req_rows.push_back('{MODE_MOVE_TAIL, 10'd2,     1'b0, '{default: '0}});

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    foreach (req_rows[i]) send_item(req_rows[i]);

    // Random phases: no idling, sender idle, receiver stalling, both
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  working_set = 8;   end
        1: begin send_idle_pct = 83; recv_stall_pct = 0;  working_set = 3;   end
        2: begin send_idle_pct = 0;  recv_stall_pct = 83; working_set = 40;  end
        default: begin send_idle_pct = 30; recv_stall_pct = 30; working_set = 16; end
      endcase
      for (int k = 0; k < RANDOM_ITEMS / PHASES; k++) send_item(random_request(working_set));
      // hold off until the block has drained
      in_tvalid <= 1'b0;
      @(posedge clk);
      while (pending_results.size() != 0) @(posedge clk);
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_cnt == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
